FILE: src/skt_pkg.sv
// Shared command and status codes for the sorted key table.
`default_nettype none
package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } skt_op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } skt_status_t;

endpackage
`default_nettype wire

FILE: src/skt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module skt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/sorted_key_table.sv
// Top level of the sorted key table: command sequencer around one key RAM.
//
// Keeps up to TABLE_DEPTH unsigned keys in ascending order (duplicates allowed)
// in a single RAM and walks it with one comparator, one entry per cycle for
// insert, search and remove. A request is taken only while the block is idle.
// Search stops at the first hit; insert into a full table and list of an
// empty table are answered in the cycle after acceptance, without a walk.
// List gives one result per stored key; once a result is taken, the next
// entry is re-read through the RAM's registered read port, so the list walk
// waits while the output is stalled. The block takes the next request once
// the last result of the current one has been taken. No clearing pass is
// needed after reset: only entries below the stored count are ever used.
`default_nettype none
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_op,
  input  wire logic [KEY_WIDTH-1:0]               in_key,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_status,
  output logic [KEY_WIDTH-1:0]                    out_entry_key,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        out_entry_count,
  output logic                                    out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_PROC,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  skt_op_t              op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] carry_r, carry_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 flag_r, flag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  skt_status_t          out_status_r, out_status_nxt;
  logic [KEY_WIDTH-1:0] out_key_r, out_key_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [KEY_WIDTH-1:0] rdata;

  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        idx_dec;
  logic                 at_end;
  logic                 res_set;
  skt_status_t          res_status;
  logic [KEY_WIDTH-1:0] res_key;
  logic                 res_last;

  skt_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign at_end  = (idx_r == cnt_r);

  // Read runs one entry ahead of the entry being processed.
  always_comb begin
    case (state_r)
      S_IDLE:  raddr = '0;
      S_ADDR:  raddr = idx_r[AW-1:0];
      S_PROC:  raddr = idx_inc[AW-1:0];
      default: raddr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    carry_nxt     = carry_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    we            = 1'b0;
    waddr         = idx_r[AW-1:0];
    wdata         = carry_r;
    res_set       = 1'b0;
    res_status    = ST_NOT_FOUND;
    res_key       = key_r;
    res_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = skt_op_t'(in_op);
          key_nxt   = in_key;
          carry_nxt = in_key;
          idx_nxt   = '0;
          flag_nxt  = 1'b0;
          if (skt_op_t'(in_op) == OP_INSERT && cnt_r == CW'(TABLE_DEPTH)) begin
            res_set    = 1'b1;
            res_status = ST_FULL;
            res_key    = in_key;
          end else if (skt_op_t'(in_op) == OP_LIST && cnt_r == '0) begin
            res_set    = 1'b1;
            res_status = ST_EMPTY;
            res_key    = '0;
          end else begin
            state_nxt = S_PROC;
          end
        end
      end
      S_ADDR: begin
        state_nxt = S_PROC;
      end
      S_PROC: begin
        case (op_r)
          OP_INSERT: begin
            // Ripple the carried key forward from the insertion point.
            if (at_end) begin
              we         = 1'b1;
              cnt_nxt    = cnt_r + CW'(1);
              res_set    = 1'b1;
              res_status = ST_INSERTED;
            end else begin
              if (flag_r || rdata >= key_r) begin
                we        = 1'b1;
                carry_nxt = rdata;
                flag_nxt  = 1'b1;
              end
              idx_nxt = idx_inc;
            end
          end
          OP_SEARCH: begin
            if (at_end) begin
              res_set    = 1'b1;
              res_status = ST_NOT_FOUND;
            end else if (rdata == key_r) begin
              res_set    = 1'b1;
              res_status = ST_FOUND;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          OP_REMOVE: begin
            if (at_end) begin
              res_set = 1'b1;
              if (flag_r) begin
                cnt_nxt    = cnt_r - CW'(1);
                res_status = ST_REMOVED;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end else begin
              // After the hit, every later entry moves up one place.
              if (flag_r) begin
                we    = 1'b1;
                waddr = idx_dec[AW-1:0];
                wdata = rdata;
              end else if (rdata == key_r) begin
                flag_nxt = 1'b1;
              end
              idx_nxt = idx_inc;
            end
          end
          default: begin
            res_set    = 1'b1;
            res_status = ST_ENTRY;
            res_key    = rdata;
            res_last   = (idx_inc == cnt_r);
            idx_nxt    = idx_inc;
          end
        endcase
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? S_IDLE : S_ADDR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_set) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_key_nxt    = res_key;
      out_count_nxt  = cnt_nxt;
      out_last_nxt   = res_last;
      state_nxt      = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    carry_r      <= carry_nxt;
    idx_r        <= idx_nxt;
    flag_r       <= flag_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_key   = out_key_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted key table: a directed command table, then random commands.
module testbench;
  import skt_pkg::*;

  localparam int DEPTH = 16;
  localparam int KW = 16;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 260;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_STEPS = 13;

  typedef struct packed {
    skt_status_t   status;
    logic [KW-1:0] key;
    logic [CW-1:0] count;
    logic          last;
  } reply_t;

  // One directed row; typed status/count apply only when pinned is set.
  typedef struct packed {
    skt_op_t       op;
    logic [KW-1:0] key;
    int            reps;
    bit            pinned;
    skt_status_t   status;
    int            count;
  } step_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [1:0]    in_op;
  logic [KW-1:0] in_key;
  logic          out_valid;
  logic          out_stall;
  logic [2:0]    out_status;
  logic [KW-1:0] out_entry_key;
  logic [CW-1:0] out_entry_count;
  logic          out_last;

  reply_t        expected_replies [$];
  logic [KW-1:0] model_keys [DEPTH];
  int            model_count = 0;
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;

  step_t steps [NUM_STEPS] = '{
    '{OP_LIST,   16'h0000,  1, 1'b1, ST_EMPTY,     0},
    '{OP_SEARCH, 16'h1234,  1, 1'b1, ST_NOT_FOUND, 0},
    '{OP_REMOVE, 16'h0000,  1, 1'b1, ST_NOT_FOUND, 0},
    '{OP_INSERT, 16'hFFFF,  1, 1'b1, ST_INSERTED,  1},
    '{OP_INSERT, 16'h0000,  1, 1'b1, ST_INSERTED,  2},
    '{OP_INSERT, 16'h8000,  2, 1'b0, ST_INSERTED,  0},
    '{OP_SEARCH, 16'hFFFF,  1, 1'b1, ST_FOUND,     4},
    '{OP_REMOVE, 16'h0000,  1, 1'b1, ST_REMOVED,   3},
    '{OP_LIST,   16'h0000,  1, 1'b0, ST_ENTRY,     0},
    '{OP_INSERT, 16'h5A5A, 13, 1'b0, ST_INSERTED,  0},
    '{OP_INSERT, 16'h0001,  1, 1'b1, ST_FULL,     16},
    '{OP_LIST,   16'hFFFF,  1, 1'b0, ST_ENTRY,     0},
    '{OP_REMOVE, 16'hFFFF,  1, 1'b1, ST_REMOVED,  15}
  };

  sorted_key_table DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_entry_key  (out_entry_key),
    .out_entry_count(out_entry_count),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Applies one command to the shadow table and queues the replies it yields.
  function automatic void predict_table_reply(input skt_op_t op, input logic [KW-1:0] key);
    int     pos;
    reply_t r;
    r.key = key;
    r.last = 1'b1;
    r.status = ST_NOT_FOUND;
    case (op)
      OP_INSERT: begin
        if (model_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < model_count && model_keys[pos] < key) pos++;
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = key;
          model_count++;
          r.status = ST_INSERTED;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < model_count; i++)
          if (model_keys[i] == key) r.status = ST_FOUND;
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < model_count && model_keys[pos] != key) pos++;
        if (pos < model_count) begin
          for (int i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
          r.status = ST_REMOVED;
        end
      end
      default: begin
        r.status = ST_EMPTY;
        r.key = '0;
      end
    endcase
    r.count = CW'(model_count);
    if (op == OP_LIST && model_count != 0) begin
      for (int i = 0; i < model_count; i++) begin
        r.status = ST_ENTRY;
        r.key = model_keys[i];
        r.last = (i == model_count - 1);
        expected_replies.push_back(r);
      end
    end else begin
      expected_replies.push_back(r);
    end
  endfunction

  task automatic issue_request(input skt_op_t op, input logic [KW-1:0] key, input bit pinned,
                               input skt_status_t status, input int count);
    int     gap;
    reply_t r;
    if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    do @(posedge clk); while (in_stall);
    predict_table_reply(op, key);
    // pinned rows are single-reply: swap in the hand-typed expectation
    if (pinned) begin
      void'(expected_replies.pop_back());
      r.status = status;
      r.key = (status == ST_EMPTY) ? '0 : key;
      r.count = CW'(count);
      r.last = 1'b1;
      expected_replies.push_back(r);
    end
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
      hold = draw_wait(recv_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d key %h count %0d last %b",
                   out_status, out_entry_key, out_entry_count, out_last);
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status || out_entry_key !== want.key ||
            out_entry_count !== want.count || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d key %h count %0d last %b, got %0d %h %0d %b",
                     want.status, want.key, want.count, want.last,
                     out_status, out_entry_key, out_entry_count, out_last);
        end
      end
    end
  end

  initial begin
    logic [KW-1:0] key_pool [8];
    logic [KW-1:0] key;
    skt_op_t       op;
    int            roll;
    int            pick;
    bit            filling;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_INSERT;
    in_key <= '0;
    foreach (key_pool[i]) key_pool[i] = KW'($urandom_range(0, 65535));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[s])
      for (int r = 0; r < steps[s].reps; r++)
        issue_request(steps[s].op, steps[s].key, steps[s].pinned, steps[s].status,
                      steps[s].count);

    // alternate drain-biased and fill-biased phases so both full and empty recur
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 55 : 20))      op = OP_INSERT;
      else if (roll < (filling ? 75 : 65)) op = OP_REMOVE;
      else if (roll < (filling ? 90 : 85)) op = OP_SEARCH;
      else                                  op = OP_LIST;
      pick = $urandom_range(0, 9);
      if (pick < 4)
        key = key_pool[$urandom_range(0, 7)];
      else if (pick < 7 && model_count > 0)
        key = model_keys[$urandom_range(0, model_count - 1)];
      else
        key = KW'($urandom_range(0, 65535));
      issue_request(op, key, 1'b0, ST_INSERTED, 0);
    end
    in_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/skt_pkg.sv
src/skt_ram.sv
src/sorted_key_table.sv
bench/testbench.sv
